// ----- hw/rtl/ismet_pkg.sv -----
`default_nettype none

package ismet_pkg;

  localparam int LATTICE_SIDE_DEFAULT = 64;

  localparam int SITE_W      = 12;
  localparam int THRESH_W    = 32;
  localparam int DE_W        = 5;
  localparam int ENERGY_W    = 15;
  localparam int ADDR_MAX_W  = 16;
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = 1'd1;

  // action codes
  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_FLIP = 1'b1;

  // decoded item handed from the front to the back
  typedef struct packed {
    logic                  action;
    logic                  spin_value;
    logic [THRESH_W-1:0]   uniform;
    logic                  in_range;
    logic [ADDR_MAX_W-1:0] center;
    logic [ADDR_MAX_W-1:0] left;
    logic [ADDR_MAX_W-1:0] right;
    logic [ADDR_MAX_W-1:0] up;
    logic [ADDR_MAX_W-1:0] down;
  } cmd_t;

  typedef struct packed {
    logic                       accepted;
    logic signed [DE_W-1:0]     energy_change;
    logic signed [ENERGY_W-1:0] total_energy;
    logic                       spin_now;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ismet_fifo.sv -----
`default_nettype none

module ismet_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ismet_front.sv -----
`default_nettype none

module ismet_front #(
  parameter int LATTICE_SIDE = ismet_pkg::LATTICE_SIDE_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_take,
  output logic                                 busy,
  input  wire logic                            action,
  input  wire logic [ismet_pkg::SITE_W-1:0]    site,
  input  wire logic                            spin_value,
  input  wire logic [ismet_pkg::THRESH_W-1:0]  uniform,
  output ismet_pkg::cmd_t                      cmd,
  output logic                                 cmd_push,
  input  wire logic                            cmd_full
);

  import ismet_pkg::*;

  localparam int SITE_COUNT  = LATTICE_SIDE * LATTICE_SIDE;
  localparam int WIDE_W      = ADDR_MAX_W + 1;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 24;
  localparam int PROD_W      = SITE_W + RECIP_W;
  localparam int ROW_W       = SITE_W;
  localparam int SIDE_W      = $clog2(LATTICE_SIDE + 1);
  localparam int MUL_W       = ROW_W + SIDE_W;

  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'((1 << RECIP_SHIFT) / LATTICE_SIDE);
  localparam logic [SIDE_W-1:0]  SIDE_V     = SIDE_W'(LATTICE_SIDE);
  localparam logic [SIDE_W-1:0]  COL_LAST   = SIDE_W'(LATTICE_SIDE - 1);
  localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(LATTICE_SIDE - 1);
  localparam logic [WIDE_W-1:0]  W_SIDE     = WIDE_W'(LATTICE_SIDE);
  localparam logic [WIDE_W-1:0]  W_SIDE_M1  = WIDE_W'(LATTICE_SIDE - 1);
  localparam logic [WIDE_W-1:0]  W_ROW_WRAP = WIDE_W'((LATTICE_SIDE - 1) * LATTICE_SIDE);
  localparam logic [WIDE_W-1:0]  W_COUNT    = WIDE_W'(SITE_COUNT);

  typedef enum logic [1:0] {F_IDLE, F_FIX, F_ADDR} fstate_t;

  fstate_t              state;
  logic                 act_q;
  logic                 spin_q;
  logic [THRESH_W-1:0]  uni_q;
  logic [SITE_W-1:0]    site_q;
  logic                 in_range_q;
  logic [ROW_W-1:0]     est;
  logic [ROW_W-1:0]     row;
  logic [SIDE_W-1:0]    col;

  logic [PROD_W-1:0]    recip_prod;
  logic [MUL_W-1:0]     base;
  logic [MUL_W-1:0]     rem;
  logic                 rem_over;
  logic [WIDE_W-1:0]    s_w;
  logic [WIDE_W-1:0]    left_w;
  logic [WIDE_W-1:0]    right_w;
  logic [WIDE_W-1:0]    up_w;
  logic [WIDE_W-1:0]    down_w;

  // row estimate by reciprocal, low by at most one
  assign recip_prod = PROD_W'(site) * PROD_W'(RECIP);
  assign base       = MUL_W'(est) * MUL_W'(SIDE_V);
  assign rem        = MUL_W'(site_q) - base;
  assign rem_over   = (rem >= MUL_W'(SIDE_V));

  // periodic neighbours from row and column
  assign s_w     = WIDE_W'(site_q);
  assign left_w  = (col == '0)       ? s_w + W_SIDE_M1  : s_w - WIDE_W'(1);
  assign right_w = (col == COL_LAST) ? s_w - W_SIDE_M1  : s_w + WIDE_W'(1);
  assign up_w    = (row == '0)       ? s_w + W_ROW_WRAP : s_w - W_SIDE;
  assign down_w  = (row == ROW_LAST) ? s_w - W_ROW_WRAP : s_w + W_SIDE;

  assign busy     = (state != F_IDLE);
  assign cmd_push = (state == F_ADDR) && !cmd_full;

  always_comb begin
    cmd.action     = act_q;
    cmd.spin_value = spin_q;
    cmd.uniform    = uni_q;
    cmd.in_range   = in_range_q;
    cmd.center     = ADDR_MAX_W'(site_q);
    cmd.left       = left_w[ADDR_MAX_W-1:0];
    cmd.right      = right_w[ADDR_MAX_W-1:0];
    cmd.up         = up_w[ADDR_MAX_W-1:0];
    cmd.down       = down_w[ADDR_MAX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (item_take) begin
            act_q      <= action;
            spin_q     <= spin_value;
            uni_q      <= uniform;
            site_q     <= site;
            in_range_q <= (WIDE_W'(site) < W_COUNT);
            est        <= recip_prod[RECIP_SHIFT +: ROW_W];
            state      <= F_FIX;
          end
        end
        F_FIX: begin
          if (rem_over) begin
            row <= est + ROW_W'(1);
            col <= SIDE_W'(rem - MUL_W'(SIDE_V));
          end else begin
            row <= est;
            col <= SIDE_W'(rem);
          end
          state <= F_ADDR;
        end
        F_ADDR: begin
          if (!cmd_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ismet_back.sv -----
`default_nettype none

module ismet_back #(
  parameter int LATTICE_SIDE = ismet_pkg::LATTICE_SIDE_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [ismet_pkg::THRESH_W-1:0] thr_four,
  input  wire logic [ismet_pkg::THRESH_W-1:0] thr_eight,
  input  wire ismet_pkg::cmd_t                cmd_in,
  input  wire logic                           cmd_empty,
  output logic                                cmd_pop,
  output ismet_pkg::res_t                     res,
  output logic                                res_push,
  input  wire logic                           res_full,
  output logic                                clearing
);

  import ismet_pkg::*;

  localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
  localparam int AW         = $clog2(SITE_COUNT);
  localparam logic [AW-1:0]       LAST_ADDR = AW'(SITE_COUNT - 1);
  localparam logic [ENERGY_W-1:0] E_RESET   = ENERGY_W'(-2 * SITE_COUNT);

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_RD0, B_RD1, B_RD2, B_EVAL, B_OUT} bstate_t;

  bstate_t             state;
  cmd_t                cmd;
  logic [AW-1:0]       clr_addr;
  logic [ENERGY_W-1:0] energy;
  logic                s_c;
  logic                n_l;
  logic                n_r;
  logic                n_u;

  logic                mem [SITE_COUNT];
  logic                rd_a;
  logic                rd_b;
  logic [AW-1:0]       ra;
  logic [AW-1:0]       rb;
  logic                we;
  logic [AW-1:0]       wa;
  logic                wd;

  logic [2:0]          up_cnt;
  logic [DE_W-1:0]     de_mag;
  logic [DE_W-1:0]     flip_de;
  logic                de_le0;
  logic                change;
  logic [ENERGY_W-1:0] energy_next;

  // count of +1 neighbours, down neighbour straight from the read port
  assign up_cnt  = 3'(n_l) + 3'(n_r) + 3'(n_u) + 3'(rd_a);
  assign de_mag  = {up_cnt[2:0], 2'b00} - DE_W'(8);
  assign flip_de = s_c ? de_mag : DE_W'(0) - de_mag;
  assign de_le0  = flip_de[DE_W-1] || (flip_de == '0);

  always_comb begin
    if (cmd.action == ACT_FLIP) begin
      priority if (de_le0) begin
        change = 1'b1;
      end else if (flip_de == DE_W'(4)) begin
        change = (cmd.uniform < thr_four);
      end else begin
        change = (cmd.uniform < thr_eight);
      end
    end else begin
      change = (cmd.spin_value != s_c);
    end
  end

  assign energy_next = energy + {{(ENERGY_W - DE_W){flip_de[DE_W-1]}}, flip_de};

  always_comb begin
    ra = cmd.center[AW-1:0];
    rb = cmd.left[AW-1:0];
    unique case (state)
      B_RD1: begin
        ra = cmd.right[AW-1:0];
        rb = cmd.up[AW-1:0];
      end
      B_RD2: begin
        ra = cmd.down[AW-1:0];
        rb = cmd.down[AW-1:0];
      end
      default: ;
    endcase
  end

  assign clearing = (state == B_CLEAR);
  assign we       = clearing || ((state == B_EVAL) && change);
  assign wa       = clearing ? clr_addr : cmd.center[AW-1:0];
  assign wd       = clearing ? 1'b1 : !s_c;
  assign cmd_pop  = (state == B_IDLE) && !cmd_empty;
  assign res_push = (state == B_OUT) && !res_full;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      energy   <= E_RESET;
    end else begin
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!cmd_empty) begin
            cmd   <= cmd_in;
            state <= B_RD0;
          end
        end
        B_RD0: begin
          if (cmd.in_range) begin
            state <= B_RD1;
          end else begin
            res.accepted      <= 1'b0;
            res.energy_change <= '0;
            res.total_energy  <= energy;
            res.spin_now      <= 1'b0;
            state             <= B_OUT;
          end
        end
        B_RD1: begin
          s_c   <= rd_a;
          n_l   <= rd_b;
          state <= B_RD2;
        end
        B_RD2: begin
          n_r   <= rd_a;
          n_u   <= rd_b;
          state <= B_EVAL;
        end
        B_EVAL: begin
          res.accepted      <= (cmd.action == ACT_FLIP) && change;
          res.energy_change <= change ? flip_de : '0;
          res.total_energy  <= change ? energy_next : energy;
          res.spin_now      <= s_c ^ change;
          if (change) begin
            energy <= energy_next;
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (!res_full) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ising_metropolis_spin_update.sv -----
// Square periodic Ising lattice with Metropolis single-spin-flip updates.
// Input queue port: push with action, site, spin_value and uniform; the item
// transfers on a clock edge with push high and full low. A set action writes
// one spin, a flip action tries a Metropolis flip against the two thresholds.
// Result queue port: while empty is low the oldest result sits on accepted,
// energy_change, total_energy and spin_now; it transfers when pop is high.
// Thresholds are written through cfg_write, cfg_index and cfg_data; the user
// must write them only at an edge the block is idle, which it does not enforce;
// index 0 is the bound for an energy rise of 4, index 1 for a rise of 8.
// The back handles one item at a time in the spin-memory sequencer, which
// reads the site and its four neighbours in three read steps on a two-read
// memory, then evaluates and writes back, then hands off the result; a site
// outside the lattice skips the reads and evaluation and goes to the hand-off.
// Reset: the spin memory is swept to all +1, one site per cycle, over all
// LATTICE_SIDE*LATTICE_SIDE sites (4096 by default); full stays high
// meanwhile. Energy starts at -2 * LATTICE_SIDE^2.
// When the consumer stalls, two results queue up, one more waits in the back,
// two decoded items wait between the front and back and one more in the
// front, and full then stays high until results drain.
`default_nettype none

module ising_metropolis_spin_update #(
  parameter int LATTICE_SIDE = ismet_pkg::LATTICE_SIDE_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [ismet_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ismet_pkg::THRESH_W-1:0]        cfg_data,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic                                  action,
  input  wire logic [ismet_pkg::SITE_W-1:0]          site,
  input  wire logic                                  spin_value,
  input  wire logic [ismet_pkg::THRESH_W-1:0]        uniform,
  input  wire logic                                  pop,
  output logic                                       empty,
  output logic                                       accepted,
  output logic signed [ismet_pkg::DE_W-1:0]          energy_change,
  output logic signed [ismet_pkg::ENERGY_W-1:0]      total_energy,
  output logic                                       spin_now
);

  import ismet_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic [THRESH_W-1:0] thr_four;
  logic [THRESH_W-1:0] thr_eight;

  logic             front_busy;
  logic             clearing;
  logic             item_take;
  cmd_t             front_cmd;
  logic             cq_push;
  logic             cq_full;
  logic [CMD_W-1:0] cq_rdata;
  logic             cq_empty;
  logic             cq_pop;
  res_t             back_res;
  logic             rq_push;
  logic             rq_full;
  logic [RES_W-1:0] rq_rdata;
  res_t             res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_four  <= '0;
      thr_eight <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_THR_FOUR:  thr_four  <= cfg_data;
        CFG_THR_EIGHT: thr_eight <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full      = front_busy || clearing;
  assign item_take = push && !full;

  ismet_front #(
    .LATTICE_SIDE (LATTICE_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_take  (item_take),
    .busy       (front_busy),
    .action     (action),
    .site       (site),
    .spin_value (spin_value),
    .uniform    (uniform),
    .cmd        (front_cmd),
    .cmd_push   (cq_push),
    .cmd_full   (cq_full)
  );

  ismet_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .full  (cq_full),
    .wdata (front_cmd),
    .pop   (cq_pop),
    .empty (cq_empty),
    .rdata (cq_rdata)
  );

  ismet_back #(
    .LATTICE_SIDE (LATTICE_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .thr_four  (thr_four),
    .thr_eight (thr_eight),
    .cmd_in    (cmd_t'(cq_rdata)),
    .cmd_empty (cq_empty),
    .cmd_pop   (cq_pop),
    .res       (back_res),
    .res_push  (rq_push),
    .res_full  (rq_full),
    .clearing  (clearing)
  );

  ismet_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .full  (rq_full),
    .wdata (back_res),
    .pop   (pop),
    .empty (empty),
    .rdata (rq_rdata)
  );

  assign res_out       = res_t'(rq_rdata);
  assign accepted      = res_out.accepted;
  assign energy_change = res_out.energy_change;
  assign total_energy  = res_out.total_energy;
  assign spin_now      = res_out.spin_now;

endmodule

`default_nettype wire

// ----- test/ising_metropolis_spin_update_tb.sv -----
module ising_metropolis_spin_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ismet_pkg::*;

  localparam int SIDE = LATTICE_SIDE_DEFAULT;
  localparam int SITES = SIDE * SIDE;
  localparam int SITE_MAX = (1 << SITE_W) - 1;
  localparam logic [THRESH_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic                action;
    logic [SITE_W-1:0]   site;
    logic                spin_value;
    logic [THRESH_W-1:0] uniform;
  } spin_cmd_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THRESH_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic action = ACT_SET;
  logic [SITE_W-1:0] site = '0;
  logic spin_value = 1'b0;
  logic [THRESH_W-1:0] uniform = '0;
  logic pop = 1'b0;
  logic empty;
  logic accepted;
  logic signed [DE_W-1:0] energy_change;
  logic signed [ENERGY_W-1:0] total_energy;
  logic spin_now;

  ising_metropolis_spin_update #(.LATTICE_SIDE(SIDE)) uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .action(action), .site(site), .spin_value(spin_value), .uniform(uniform),
    .pop(pop), .empty(empty),
    .accepted(accepted), .energy_change(energy_change),
    .total_energy(total_energy), .spin_now(spin_now)
  );

  // lattice copy and thresholds mirrored in the testbench
  bit spin_map [SITES];
  logic signed [ENERGY_W-1:0] energy_now;
  logic [THRESH_W-1:0] thr_four;
  logic [THRESH_W-1:0] thr_eight;

  spin_cmd_t pending_cmds[$];
  res_t expected_results[$];
  int mismatches = 0;

  logic cmd_taken = 1'b0;
  int send_gap = 0;
  bit send_burst = 1'b0;
  int hold_gap = 0;
  bit take_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int spin_of(int idx);
    return spin_map[idx] ? 1 : -1;
  endfunction

  function automatic res_t predict_update(spin_cmd_t cmd);
    res_t r;
    int idx, row, col, nsum, flip_de;
    bit change;
    r = '0;
    change = 1'b0;
    idx = int'(cmd.site);
    if (idx < SITES) begin
      row = idx / SIDE;
      col = idx % SIDE;
      // four wrapped neighbours, summed even when they coincide
      nsum = spin_of(row * SIDE + (col + SIDE - 1) % SIDE)
           + spin_of(row * SIDE + (col + 1) % SIDE)
           + spin_of(((row + SIDE - 1) % SIDE) * SIDE + col)
           + spin_of(((row + 1) % SIDE) * SIDE + col);
      flip_de = 2 * spin_of(idx) * nsum;
      if (cmd.action == ACT_SET) begin
        change = (cmd.spin_value != spin_map[idx]);
      end else begin
        if (flip_de <= 0) change = 1'b1;
        else if (flip_de == 4) change = cmd.uniform < thr_four;
        else change = cmd.uniform < thr_eight;
        r.accepted = change;
      end
      if (change) begin
        r.energy_change = DE_W'(flip_de);
        spin_map[idx] = !spin_map[idx];
        energy_now = energy_now + ENERGY_W'(flip_de);
      end
      r.spin_now = spin_map[idx];
    end
    r.total_energy = energy_now;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < 100)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // input side: hold the item until it transfers, then gap or load the next one
  always @(negedge clk) begin
    spin_cmd_t cmd;
    if (!rst && (!push || cmd_taken)) begin
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        cmd = pending_cmds.pop_front();
        action <= cmd.action;
        site <= cmd.site;
        spin_value <= cmd.spin_value;
        uniform <= cmd.uniform;
        push <= 1'b1;
        send_gap <= pick_gap(send_burst);
        if ($urandom_range(0, 49) == 0) send_burst <= !send_burst;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (hold_gap > 0) begin
      pop <= 1'b0;
      hold_gap <= hold_gap - 1;
    end else begin
      pop <= 1'b1;
      hold_gap <= pick_gap(take_burst);
      if ($urandom_range(0, 99) == 0) take_burst <= !take_burst;
    end
  end

  always @(posedge clk) begin
    spin_cmd_t got_cmd;
    res_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= push && !full;
      if (push && !full) begin
        got_cmd = '{action, site, spin_value, uniform};
        expected_results.push_back(predict_update(got_cmd));
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transfer", total_energy, 0);
        end else begin
          want = expected_results.pop_front();
          if (accepted !== want.accepted)
            report_mismatch("accepted", accepted, want.accepted);
          if (energy_change !== want.energy_change)
            report_mismatch("energy_change", energy_change, want.energy_change);
          if (total_energy !== want.total_energy)
            report_mismatch("total_energy", total_energy, want.total_energy);
          if (spin_now !== want.spin_now)
            report_mismatch("spin_now", spin_now, want.spin_now);
        end
      end
    end
  end

  function automatic void queue_cmd(logic act, int where, logic val,
                                    logic [THRESH_W-1:0] uni);
    spin_cmd_t c;
    c.action = act;
    c.site = SITE_W'(where);
    c.spin_value = val;
    c.uniform = uni;
    pending_cmds.push_back(c);
  endfunction

  // mostly small wrapped windows so neighbourhoods get mixed
  function automatic int pick_site(int base_row, int base_col);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return (($urandom_range(0, 7) + SIDE - 3) % SIDE) * SIDE
           + ($urandom_range(0, 7) + SIDE - 3) % SIDE;
    if (r < 85)
      return ((base_row + $urandom_range(0, 3)) % SIDE) * SIDE
           + (base_col + $urandom_range(0, 3)) % SIDE;
    return $urandom_range(0, SITE_MAX);
  endfunction

  function automatic logic [THRESH_W-1:0] pick_uniform();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom();
    if (r < 85) return THRESH_W'(thr_four + $urandom_range(0, 2) - 1);
    if (r < 95) return THRESH_W'(thr_eight + $urandom_range(0, 2) - 1);
    if (r < 98) return '0;
    return ALL_ONES;
  endfunction

  task automatic settle(int tail);
    while (pending_cmds.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_THR_FOUR) thr_four = value;
    else thr_eight = value;
  endtask

  task automatic run_random(logic [THRESH_W-1:0] four, logic [THRESH_W-1:0] eight,
                            int count);
    int base_row, base_col;
    settle(10);
    write_threshold(CFG_THR_FOUR, four);
    write_threshold(CFG_THR_EIGHT, eight);
    base_row = 0;
    base_col = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        base_row = $urandom_range(0, SIDE - 1);
        base_col = $urandom_range(0, SIDE - 1);
      end
      if ($urandom_range(0, 9) < 7)
        queue_cmd(ACT_FLIP, pick_site(base_row, base_col), $urandom_range(0, 1),
                  pick_uniform());
      else
        queue_cmd(ACT_SET, pick_site(base_row, base_col), $urandom_range(0, 1),
                  pick_uniform());
    end
  endtask

  function automatic logic [THRESH_W-1:0] square_frac(logic [THRESH_W-1:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(x);
    return prod[63:32];
  endfunction

  initial begin
    logic [THRESH_W-1:0] t4;
    for (int i = 0; i < SITES; i++) spin_map[i] = 1'b1;
    energy_now = ENERGY_W'(-2 * SITES);
    thr_four = '0;
    thr_eight = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    // memory sweep after reset keeps full high
    while (full) @(posedge clk);

    // both thresholds zero: only downhill or level flips go through
    write_threshold(CFG_THR_FOUR, '0);
    write_threshold(CFG_THR_EIGHT, '0);
    queue_cmd(ACT_FLIP, 0, 1'b0, '0);
    queue_cmd(ACT_SET, 0, 1'b1, '0);
    queue_cmd(ACT_SET, 0, 1'b0, '0);
    queue_cmd(ACT_FLIP, 0, 1'b1, ALL_ONES);
    queue_cmd(ACT_SET, SITE_MAX, 1'b0, ALL_ONES);
    queue_cmd(ACT_SET, SIDE - 1, 1'b0, '0);
    queue_cmd(ACT_SET, SITES - SIDE, 1'b0, '0);
    queue_cmd(ACT_FLIP, 0, 1'b0, 32'h5555_5555);
    queue_cmd(ACT_SET, 1, 1'b0, 32'hAAAA_AAAA);
    queue_cmd(ACT_FLIP, 2, 1'b1, '0);
    queue_cmd(ACT_FLIP, 0, 1'b0, $urandom());
    settle(10);

    // both thresholds at the top
    write_threshold(CFG_THR_FOUR, ALL_ONES);
    write_threshold(CFG_THR_EIGHT, ALL_ONES);
    queue_cmd(ACT_FLIP, 2, 1'b0, ALL_ONES);
    queue_cmd(ACT_FLIP, 2, 1'b0, ALL_ONES - 1);
    queue_cmd(ACT_FLIP, 200, 1'b1, '0);
    queue_cmd(ACT_SET, 200, 1'b1, ALL_ONES);
    settle(10);

    // uniform right at and just under each bound
    write_threshold(CFG_THR_FOUR, 32'h8000_0000);
    write_threshold(CFG_THR_EIGHT, 32'h4000_0000);
    queue_cmd(ACT_FLIP, 2080, 1'b0, 32'h4000_0000);
    queue_cmd(ACT_FLIP, 2080, 1'b0, 32'h3FFF_FFFF);
    queue_cmd(ACT_SET, 1001, 1'b0, '0);
    queue_cmd(ACT_FLIP, 1002, 1'b0, 32'h8000_0000);
    queue_cmd(ACT_FLIP, 1002, 1'b1, 32'h7FFF_FFFF);
    queue_cmd(ACT_FLIP, 1002, 1'b1, '0);

    run_random('0, '0, 250);
    run_random(ALL_ONES, ALL_ONES, 250);
    repeat (3) begin
      t4 = $urandom();
      run_random(t4, square_frac(t4), 250);
    end
    run_random(ALL_ONES, '0, 200);
    run_random('0, ALL_ONES, 200);
    run_random($urandom(), $urandom(), 150);

    settle(20);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // timeout guard against a hung run
  initial begin
    #9_600_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ismet_pkg.sv
hw/rtl/ismet_fifo.sv
hw/rtl/ismet_front.sv
hw/rtl/ismet_back.sv
hw/rtl/ising_metropolis_spin_update.sv
test/ising_metropolis_spin_update_tb.sv
